// ===== rtl/cube_to_equirect_coord_map_defines.svh =====
// cube_to_equirect_coord_map_defines.svh
// assertion macros for the cube face coordinate mapper rtl
// no dependencies; included by the files that assert
`ifndef CUBE_TO_EQUIRECT_COORD_MAP_DEFINES_SVH
`define CUBE_TO_EQUIRECT_COORD_MAP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CTEM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CTEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctem_pkg.sv =====
// ctem_pkg.sv
// widths, codes, cordic table and helpers for the cube face coordinate mapper
// no dependencies
package ctem_pkg;

    // field and register widths
    localparam int COL_W   = 13;
    localparam int FS_W    = 12;
    localparam int PD_W    = 14;
    localparam int SPAN_W  = 17;
    localparam int FACE_W  = 3;
    localparam int COORD_W = 20;
    localparam int PADDR_W = 5;

    // range limits and output format
    localparam int MAX_PANO_DIM  = 8192;
    localparam int MAX_FACE_SIZE = 2048;
    localparam int FRAC_BITS     = 8;

    // angle path: |2col-w|*span fits 31 bits, shifted up by 15 (theta) or 14 (phi)
    localparam int ANG_NUM_W = 46;
    localparam int ANG_W     = 48;
    localparam int EPS_DEN_W = 18;

    // cordic datapath
    localparam int CW       = 34;
    localparam int CORDIC_N = 30;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sh0_26DD_3B6A;
    localparam logic signed [CW-1:0] Q30_ONE  = 34'sh0_4000_0000;
    localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // face coordinate path
    localparam int SC_W   = $clog2(MAX_FACE_SIZE) + FRAC_BITS;
    localparam int PROD_W = SC_W + 32;

    // face codes
    localparam logic [FACE_W-1:0] FACE_FRONT = 3'd0;
    localparam logic [FACE_W-1:0] FACE_LEFT  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_RIGHT = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BACK  = 3'd3;
    localparam logic [FACE_W-1:0] FACE_TOP   = 3'd4;
    localparam logic [FACE_W-1:0] FACE_DOWN  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_FACE_SIZE   = 3'd0;
    localparam logic [2:0] REG_PANO_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PANO_HEIGHT = 3'd2;
    localparam logic [2:0] REG_HORIZ_SPAN  = 3'd3;
    localparam logic [2:0] REG_VERT_SPAN   = 3'd4;

    typedef logic [FACE_W-1:0] face_t;

    typedef struct packed {
        logic                 neg;
        logic signed [CW-1:0] z;
    } wrap_t;

    // fold an angle in 2^-32 turn into [-quarter, quarter] turn
    function automatic wrap_t prewrap(input logic [31:0] a);
        wrap_t r;
        r.z   = CW'(signed'(a));
        r.neg = 1'b0;
        if (r.z > 34'sh0_4000_0000) begin
            r.z   = r.z - 34'sh0_8000_0000;
            r.neg = 1'b1;
        end else if (r.z < -34'sh0_4000_0000) begin
            r.z   = r.z + 34'sh0_8000_0000;
            r.neg = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ctem_div.sv =====
// ctem_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on nothing; quotient must be below 2^QUO_W
module ctem_div #(
    parameter int NUM_W  = 46,
    parameter int DEN_W  = 14,
    parameter int QUO_W  = 46,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_i,
    input  logic [NUM_W-1:0]  num_i,
    input  logic [DEN_W-1:0]  den_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output logic [QUO_W-1:0]  quo_o,
    output logic [SIDE_W-1:0] side_o
);

    localparam int WW = NUM_W + DEN_W + QUO_W;

    logic              vld_reg  [QUO_W];
    logic [NUM_W-1:0]  rem_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    genvar k;
    for (k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic              vp;
        logic [NUM_W-1:0]  rp;
        logic [DEN_W-1:0]  dp;
        logic [QUO_W-1:0]  qp;
        logic [SIDE_W-1:0] sp;
        logic [WW-1:0]     trial;
        logic              take;
        logic [NUM_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_src
            assign vp = valid_i;
            assign rp = num_i;
            assign dp = den_i;
            assign qp = '0;
            assign sp = side_i;
        end else begin : g_src
            assign vp = vld_reg[k-1];
            assign rp = rem_reg[k-1];
            assign dp = den_reg[k-1];
            assign qp = quo_reg[k-1];
            assign sp = side_reg[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb begin
            trial    = WW'(dp) << B;
            take     = WW'(rp) >= trial;
            rem_next = take ? NUM_W'(WW'(rp) - trial) : rp;
            quo_next = qp;
            quo_next[B] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= dp;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= sp;
            end
        end
    end

    assign valid_o = vld_reg[QUO_W-1];
    assign quo_o   = quo_reg[QUO_W-1];
    assign side_o  = side_reg[QUO_W-1];

endmodule

// ===== rtl/ctem_cordic.sv =====
// ctem_cordic.sv
// pipelined cordic, rotation or vectoring mode, one iteration per stage
// depends on ctem_pkg for the arctangent table and widths
module ctem_cordic #(
    parameter bit VECT   = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_i,
    input  logic signed [ctem_pkg::CW-1:0] x_i,
    input  logic signed [ctem_pkg::CW-1:0] y_i,
    input  logic signed [ctem_pkg::CW-1:0] z_i,
    input  logic [SIDE_W-1:0]             side_i,
    output logic                          valid_o,
    output logic signed [ctem_pkg::CW-1:0] x_o,
    output logic signed [ctem_pkg::CW-1:0] y_o,
    output logic signed [ctem_pkg::CW-1:0] z_o,
    output logic [SIDE_W-1:0]             side_o
);
    import ctem_pkg::*;

    logic                 vld_reg  [CORDIC_N];
    logic signed [CW-1:0] x_reg    [CORDIC_N];
    logic signed [CW-1:0] y_reg    [CORDIC_N];
    logic signed [CW-1:0] z_reg    [CORDIC_N];
    logic [SIDE_W-1:0]    side_reg [CORDIC_N];

    genvar i;
    for (i = 0; i < CORDIC_N; i++) begin : g_iter
        localparam logic signed [CW-1:0] ANG = CW'(ATAN_TAB[i]);
        logic                 vp;
        logic signed [CW-1:0] xp, yp, zp;
        logic [SIDE_W-1:0]    sp;
        logic signed [CW-1:0] dx, dy;
        logic                 d;

        if (i == 0) begin : g_src
            assign vp = valid_i;
            assign xp = x_i;
            assign yp = y_i;
            assign zp = z_i;
            assign sp = side_i;
        end else begin : g_src
            assign vp = vld_reg[i-1];
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign sp = side_reg[i-1];
        end

        // floor shifts and direction of this micro-rotation
        always_comb begin
            dx = yp >>> i;
            dy = xp >>> i;
            d  = VECT ? (yp > 0) : (zp < 0);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (d) begin
                    x_reg[i] <= xp + dx;
                    y_reg[i] <= yp - dy;
                    z_reg[i] <= zp + ANG;
                end else begin
                    x_reg[i] <= xp - dx;
                    y_reg[i] <= yp + dy;
                    z_reg[i] <= zp - ANG;
                end
                side_reg[i] <= sp;
            end
        end
    end

    assign valid_o = vld_reg[CORDIC_N-1];
    assign x_o     = x_reg[CORDIC_N-1];
    assign y_o     = y_reg[CORDIC_N-1];
    assign z_o     = z_reg[CORDIC_N-1];
    assign side_o  = side_reg[CORDIC_N-1];

endmodule

// ===== rtl/cube_to_equirect_coord_map.sv =====
// Throughput: one item per cycle while the skid is empty; the 46-stage
// angle dividers, two 30-stage cordic levels in series and the 19-stage
// face coordinate dividers are fully pipelined. A one-entry skid after the
// output register keeps s_tready high while one result waits. Reset (aresetn
// low, synchronous) empties the pipeline and loads the register defaults; no
// clearing pass is needed.
`include "cube_to_equirect_coord_map_defines.svh"
module cube_to_equirect_coord_map (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,  // col[12:0], row[25:13]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,  // face[2:0], face_x[22:3], face_y[42:23]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ctem_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ctem_pkg::*;

    localparam logic signed [ANG_W-1:0] T8  = 48'sh0000_2000_0000;
    localparam logic signed [ANG_W-1:0] T38 = 48'sh0000_6000_0000;
    localparam logic signed [ANG_W-1:0] T4  = 48'sh0000_4000_0000;
    localparam logic signed [ANG_W-1:0] T2  = 48'sh0000_8000_0000;

    // configuration registers
    logic [FS_W-1:0]   cfg_fs_reg;
    logic [PD_W-1:0]   cfg_pw_reg, cfg_ph_reg;
    logic [SPAN_W-1:0] cfg_hs_reg, cfg_vs_reg;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_fs_reg <= 12'd512;
            cfg_pw_reg <= 14'd2048;
            cfg_ph_reg <= 14'd1024;
            cfg_hs_reg <= 17'd65536;
            cfg_vs_reg <= 17'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FACE_SIZE:   cfg_fs_reg <= pwdata[FS_W-1:0];
                REG_PANO_WIDTH:  cfg_pw_reg <= pwdata[PD_W-1:0];
                REG_PANO_HEIGHT: cfg_ph_reg <= pwdata[PD_W-1:0];
                REG_HORIZ_SPAN:  cfg_hs_reg <= pwdata[SPAN_W-1:0];
                REG_VERT_SPAN:   cfg_vs_reg <= pwdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            REG_FACE_SIZE:   prdata = 32'(cfg_fs_reg);
            REG_PANO_WIDTH:  prdata = 32'(cfg_pw_reg);
            REG_PANO_HEIGHT: prdata = 32'(cfg_ph_reg);
            REG_HORIZ_SPAN:  prdata = 32'(cfg_hs_reg);
            REG_VERT_SPAN:   prdata = 32'(cfg_vs_reg);
            default:         prdata = '0;
        endcase
    end

    // effective register values: zero counts as one, large values clamp
    logic [FS_W-1:0] fs_eff;
    logic [PD_W-1:0] pw_eff, ph_eff;
    logic [SC_W-1:0] scale;
    logic [SC_W:0]   top;

    always_comb begin
        fs_eff = (cfg_fs_reg == '0) ? FS_W'(1) :
                 (cfg_fs_reg > FS_W'(MAX_FACE_SIZE)) ? FS_W'(MAX_FACE_SIZE) : cfg_fs_reg;
        pw_eff = (cfg_pw_reg == '0) ? PD_W'(1) :
                 (cfg_pw_reg > PD_W'(MAX_PANO_DIM)) ? PD_W'(MAX_PANO_DIM) : cfg_pw_reg;
        ph_eff = (cfg_ph_reg == '0) ? PD_W'(1) :
                 (cfg_ph_reg > PD_W'(MAX_PANO_DIM)) ? PD_W'(MAX_PANO_DIM) : cfg_ph_reg;
        scale  = SC_W'(fs_eff) << (FRAC_BITS - 1);
        top    = {scale, 1'b0};
    end

    // global advance: the pipeline moves while the skid is empty
    logic en;
    logic skid_full_reg;

    assign en       = !skid_full_reg;
    assign s_tready = en;

    // input register
    logic             v0_reg;
    logic [COL_W-1:0] col_reg, row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg <= s_tdata[12:0];
            row_reg <= s_tdata[25:13];
        end
    end

    // centred pixel offsets times the spans, and the epsilon divisor
    logic signed [15:0] dt, dp;
    logic [13:0]        mt, mp;
    logic               v1_reg, sgt_reg, sgp_reg;
    logic [30:0]        nt_reg, np_reg;
    logic [EPS_DEN_W-1:0] de_reg;

    always_comb begin
        dt = signed'({2'b00, col_reg, 1'b0}) - signed'({2'b00, pw_eff});
        dp = signed'({2'b00, row_reg, 1'b0}) - signed'({2'b00, ph_eff});
        mt = dt[15] ? 14'(-dt) : dt[13:0];
        mp = dp[15] ? 14'(-dp) : dp[13:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sgt_reg <= dt[15];
            sgp_reg <= dp[15];
            nt_reg  <= 31'(mt) * 31'(cfg_hs_reg);
            np_reg  <= 31'(mp) * 31'(cfg_vs_reg);
            de_reg  <= EPS_DEN_W'(fs_eff) * EPS_DEN_W'(80);
        end
    end

    // angle and epsilon dividers
    logic                 vd;
    logic [ANG_NUM_W-1:0] qt, qp, qe;
    logic                 sgt_d, sgp_d;

    ctem_div #(.NUM_W(ANG_NUM_W), .DEN_W(PD_W), .QUO_W(ANG_NUM_W), .SIDE_W(1)) u_div_theta (
        .aclk, .aresetn, .en,
        .valid_i (v1_reg),
        .num_i   ({nt_reg, 15'b0}),
        .den_i   (pw_eff),
        .side_i  (sgt_reg),
        .valid_o (vd),
        .quo_o   (qt),
        .side_o  (sgt_d)
    );

    ctem_div #(.NUM_W(ANG_NUM_W), .DEN_W(PD_W), .QUO_W(ANG_NUM_W), .SIDE_W(1)) u_div_phi (
        .aclk, .aresetn, .en,
        .valid_i (v1_reg),
        .num_i   ({1'b0, np_reg, 14'b0}),
        .den_i   (ph_eff),
        .side_i  (sgp_reg),
        .valid_o (),
        .quo_o   (qp),
        .side_o  (sgp_d)
    );

    ctem_div #(.NUM_W(ANG_NUM_W), .DEN_W(EPS_DEN_W), .QUO_W(ANG_NUM_W), .SIDE_W(1)) u_div_eps (
        .aclk, .aresetn, .en,
        .valid_i (v1_reg),
        .num_i   (ANG_NUM_W'(64'h1_0000_0000)),
        .den_i   (de_reg),
        .side_i  (1'b0),
        .valid_o (),
        .quo_o   (qe),
        .side_o  ()
    );

    // side face choice by longitude
    logic signed [ANG_W-1:0] theta, phi, eps, lo0, hi0, lo1, hi2, loc;
    face_t                   face0;
    logic                    v2_reg;
    face_t                   face0_reg;
    logic [31:0]             loc_reg, th_reg;
    logic signed [ANG_W-1:0] phi_reg;

    always_comb begin
        theta = sgt_d ? -signed'({2'b00, qt}) : signed'({2'b00, qt});
        phi   = sgp_d ? -signed'({2'b00, qp}) : signed'({2'b00, qp});
        eps   = signed'({2'b00, qe});
        lo0   = -T8 - eps;
        hi0   = T8 - eps;
        lo1   = -T38 - eps;
        hi2   = T38 - eps;
        if (theta > lo0 && theta <= hi0) begin
            face0 = FACE_FRONT;
            loc   = theta;
        end else if (theta > lo1 && theta <= lo0) begin
            face0 = FACE_LEFT;
            loc   = theta + T4;
        end else if (theta > hi0 && theta <= hi2) begin
            face0 = FACE_RIGHT;
            loc   = theta - T4;
        end else begin
            face0 = FACE_BACK;
            loc   = (theta > 0) ? theta - T2 : theta + T2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face0_reg <= face0;
            loc_reg   <= loc[31:0];
            th_reg    <= theta[31:0];
            phi_reg   <= phi;
        end
    end

    // cosine of local longitude, sine and cosine of longitude and latitude
    wrap_t                wl, wt, wp;
    logic                 vc;
    logic signed [CW-1:0] xl, xt, yt, xp, yp;
    logic                 negl_c, negt_c, negp_c;
    face_t                face0_c;
    logic signed [ANG_W-1:0] phi_c;

    always_comb begin
        wl = prewrap(loc_reg);
        wt = prewrap(th_reg);
        wp = prewrap(phi_reg[31:0]);
    end

    ctem_cordic #(.VECT(1'b0), .SIDE_W(FACE_W + ANG_W + 1)) u_sc_local (
        .aclk, .aresetn, .en,
        .valid_i (v2_reg),
        .x_i     (CORDIC_K),
        .y_i     ('0),
        .z_i     (wl.z),
        .side_i  ({face0_reg, phi_reg, wl.neg}),
        .valid_o (vc),
        .x_o     (xl),
        .y_o     (),
        .z_o     (),
        .side_o  ({face0_c, phi_c, negl_c})
    );

    ctem_cordic #(.VECT(1'b0), .SIDE_W(1)) u_sc_theta (
        .aclk, .aresetn, .en,
        .valid_i (v2_reg),
        .x_i     (CORDIC_K),
        .y_i     ('0),
        .z_i     (wt.z),
        .side_i  (wt.neg),
        .valid_o (),
        .x_o     (xt),
        .y_o     (yt),
        .z_o     (),
        .side_o  (negt_c)
    );

    ctem_cordic #(.VECT(1'b0), .SIDE_W(1)) u_sc_phi (
        .aclk, .aresetn, .en,
        .valid_i (v2_reg),
        .x_i     (CORDIC_K),
        .y_i     ('0),
        .z_i     (wp.z),
        .side_i  (wp.neg),
        .valid_o (),
        .x_o     (xp),
        .y_o     (yp),
        .z_o     (),
        .side_o  (negp_c)
    );

    // latitude threshold via arctangent of |cos(local)|
    logic signed [CW-1:0] cl, ct, st, cp, sp, abs_cl;
    logic                 cl_pos, cl_zero;
    localparam int VSIDE_W = FACE_W + ANG_W + 2 + 4 * CW;
    logic                 va;
    logic signed [CW-1:0] za;
    face_t                face0_a;
    logic signed [ANG_W-1:0] phi_a;
    logic                 cl_pos_a, cl_zero_a;
    logic signed [CW-1:0] ct_a, st_a, cp_a, sp_a;

    always_comb begin
        cl      = negl_c ? -xl : xl;
        ct      = negt_c ? -xt : xt;
        st      = negt_c ? -yt : yt;
        cp      = negp_c ? -xp : xp;
        sp      = negp_c ? -yp : yp;
        cl_pos  = cl > 0;
        cl_zero = cl == 0;
        abs_cl  = cl[CW-1] ? -cl : cl;
    end

    ctem_cordic #(.VECT(1'b1), .SIDE_W(VSIDE_W)) u_atan (
        .aclk, .aresetn, .en,
        .valid_i (vc),
        .x_i     (Q30_ONE),
        .y_i     (abs_cl),
        .z_i     ('0),
        .side_i  ({face0_c, phi_c, cl_pos, cl_zero, ct, st, cp, sp}),
        .valid_o (va),
        .x_o     (),
        .y_o     (),
        .z_o     (za),
        .side_o  ({face0_a, phi_a, cl_pos_a, cl_zero_a, ct_a, st_a, cp_a, sp_a})
    );

    // final face and direction vector
    logic signed [ANG_W-1:0] thr;
    face_t                   face5;
    logic signed [63:0]      pxx, pzz;
    logic                    v5_reg;
    face_t                   face5_reg;
    logic signed [CW-1:0]    vx_reg, vy_reg, vz_reg;

    always_comb begin
        if (cl_pos_a) begin
            thr = ANG_W'(za);
        end else if (cl_zero_a) begin
            thr = '0;
        end else begin
            thr = T2 - ANG_W'(za);
        end
        if (phi_a > thr) begin
            face5 = FACE_DOWN;
        end else if (phi_a < -thr) begin
            face5 = FACE_TOP;
        end else begin
            face5 = face0_a;
        end
        pxx = 64'(signed'(cp_a[31:0])) * 64'(signed'(ct_a[31:0]));
        pzz = 64'(signed'(cp_a[31:0])) * 64'(signed'(st_a[31:0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= va;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face5_reg <= face5;
            vx_reg    <= pxx[63:30];
            vy_reg    <= sp_a;
            vz_reg    <= pzz[63:30];
        end
    end

    // project onto the face: axis and in-plane components
    logic signed [CW-1:0] ax, nx, ny;
    logic [31:0]          abs_a, abs_x, abs_y;
    logic                 v6_reg, az_reg, sgx_reg, sgy_reg;
    logic                 npx_reg, nnx_reg, npy_reg, nny_reg;
    face_t                face6_reg;
    logic [31:0]          aa_reg;
    logic [PROD_W-1:0]    px_reg, py_reg;

    always_comb begin
        case (face5_reg)
            FACE_FRONT: begin ax = vx_reg; nx = vz_reg;  ny = vy_reg;  end
            FACE_LEFT:  begin ax = vz_reg; nx = -vx_reg; ny = -vy_reg; end
            FACE_RIGHT: begin ax = vz_reg; nx = -vx_reg; ny = vy_reg;  end
            FACE_BACK:  begin ax = vx_reg; nx = vz_reg;  ny = -vy_reg; end
            FACE_TOP:   begin ax = vy_reg; nx = -vz_reg; ny = -vx_reg; end
            default:    begin ax = vy_reg; nx = vz_reg;  ny = -vx_reg; end
        endcase
        abs_a = ax[CW-1] ? 32'(-ax) : ax[31:0];
        abs_x = nx[CW-1] ? 32'(-nx) : nx[31:0];
        abs_y = ny[CW-1] ? 32'(-ny) : ny[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face6_reg <= face5_reg;
            aa_reg    <= abs_a;
            az_reg    <= ax == 0;
            sgx_reg   <= nx[CW-1] ^ ax[CW-1];
            sgy_reg   <= ny[CW-1] ^ ax[CW-1];
            npx_reg   <= nx > 0;
            nnx_reg   <= nx < 0;
            npy_reg   <= ny > 0;
            nny_reg   <= ny < 0;
            px_reg    <= PROD_W'(scale) * PROD_W'(abs_x);
            py_reg    <= PROD_W'(scale) * PROD_W'(abs_y);
        end
    end

    // overflow check so the divider needs only SC_W quotient bits
    logic [PROD_W-1:0] lim;
    logic              v7_reg, ovx_reg, ovy_reg, az7_reg;
    logic              sgx7_reg, sgy7_reg, npx7_reg, nnx7_reg, npy7_reg, nny7_reg;
    face_t             face7_reg;
    logic [31:0]       den7_reg;
    logic [PROD_W-1:0] nmx_reg, nmy_reg;

    assign lim = {aa_reg, {SC_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ovx_reg   <= px_reg >= lim;
            ovy_reg   <= py_reg >= lim;
            nmx_reg   <= (px_reg >= lim) ? '0 : px_reg;
            nmy_reg   <= (py_reg >= lim) ? '0 : py_reg;
            den7_reg  <= az_reg ? 32'd1 : aa_reg;
            az7_reg   <= az_reg;
            sgx7_reg  <= sgx_reg;
            sgy7_reg  <= sgy_reg;
            npx7_reg  <= npx_reg;
            nnx7_reg  <= nnx_reg;
            npy7_reg  <= npy_reg;
            nny7_reg  <= nny_reg;
            face7_reg <= face6_reg;
        end
    end

    // face coordinate dividers
    logic            fin_v;
    logic [SC_W-1:0] qx, qy;
    face_t           face_f;
    logic            az_f, ovx_f, sgx_f, npx_f, nnx_f, ovy_f, sgy_f, npy_f, nny_f;

    ctem_div #(.NUM_W(PROD_W), .DEN_W(32), .QUO_W(SC_W), .SIDE_W(FACE_W + 5)) u_div_x (
        .aclk, .aresetn, .en,
        .valid_i (v7_reg),
        .num_i   (nmx_reg),
        .den_i   (den7_reg),
        .side_i  ({face7_reg, az7_reg, ovx_reg, sgx7_reg, npx7_reg, nnx7_reg}),
        .valid_o (fin_v),
        .quo_o   (qx),
        .side_o  ({face_f, az_f, ovx_f, sgx_f, npx_f, nnx_f})
    );

    ctem_div #(.NUM_W(PROD_W), .DEN_W(32), .QUO_W(SC_W), .SIDE_W(4)) u_div_y (
        .aclk, .aresetn, .en,
        .valid_i (v7_reg),
        .num_i   (nmy_reg),
        .den_i   (den7_reg),
        .side_i  ({ovy_reg, sgy7_reg, npy7_reg, nny7_reg}),
        .valid_o (),
        .quo_o   (qy),
        .side_o  ({ovy_f, sgy_f, npy_f, nny_f})
    );

    // offset by half the face and saturate to [0, face_size]
    function automatic logic [COORD_W-1:0] coord(
        input logic [SC_W-1:0] sc,
        input logic [SC_W:0]   tp,
        input logic [SC_W-1:0] q,
        input logic            ov,
        input logic            sg,
        input logic            az,
        input logic            np,
        input logic            nn
    );
        logic signed [SC_W+2:0] s;
        logic [COORD_W-1:0]     r;
        if (az) begin
            r = np ? COORD_W'(tp) : (nn ? '0 : COORD_W'(sc));
        end else if (ov) begin
            r = sg ? '0 : COORD_W'(tp);
        end else begin
            s = sg ? signed'({3'b000, sc}) - signed'({3'b000, q})
                   : signed'({3'b000, sc}) + signed'({3'b000, q});
            if (s < 0) begin
                r = '0;
            end else if (s > signed'({2'b00, tp})) begin
                r = COORD_W'(tp);
            end else begin
                r = COORD_W'(s);
            end
        end
        return r;
    endfunction

    logic [COORD_W-1:0] fx, fy;

    always_comb begin
        fx = coord(scale, top, qx, ovx_f, sgx_f, az_f, npx_f, nnx_f);
        fy = coord(scale, top, qy, ovy_f, sgy_f, az_f, npy_f, nny_f);
    end

    // output register and one-entry skid
    logic               m_tvalid_reg;
    face_t              out_face_reg, skid_face_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_full_reg) begin
                m_tvalid_reg  <= 1'b1;
                skid_full_reg <= 1'b0;
                out_face_reg  <= skid_face_reg;
                out_x_reg     <= skid_x_reg;
                out_y_reg     <= skid_y_reg;
            end else if (en && fin_v) begin
                m_tvalid_reg <= 1'b1;
                out_face_reg <= face_f;
                out_x_reg    <= fx;
                out_y_reg    <= fy;
            end else begin
                m_tvalid_reg <= 1'b0;
            end
        end else if (en && fin_v) begin
            skid_full_reg <= 1'b1;
            skid_face_reg <= face_f;
            skid_x_reg    <= fx;
            skid_y_reg    <= fy;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, out_y_reg, out_x_reg, out_face_reg};

    // checks on the output buffering
    `CTEM_ASSERT_IMPL(a_skid_behind_out, skid_full_reg, m_tvalid_reg, "skid full with output empty")
    `CTEM_ASSERT_IMPL(a_skid_fill_cause, $rose(skid_full_reg), $past(m_tvalid_reg && !m_tready), "skid filled without stall")
    `CTEM_ASSERT_NEXT(a_stall_to_skid, m_tvalid_reg && !m_tready && en && fin_v, skid_full_reg, "stalled result lost")
    `CTEM_ASSERT_IMPL(a_face_code, m_tvalid_reg, out_face_reg <= FACE_DOWN, "face code out of range")

endmodule

// ===== bench/tb.sv =====
// tb.sv
// self-checking bench for cube_to_equirect_coord_map: stream stimulus, apb set-up,
// in-bench face/coordinate predictor; depends on ctem_pkg and the rtl only
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctem_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [2:0]  face;
        logic [19:0] fx;
        logic [19:0] fy;
    } face_hit_t;

    typedef struct {
        int col;
        int row;
        int face; // -1 where the face is not obvious
    } pix_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the configuration registers
    logic [11:0] sh_fs;
    logic [13:0] sh_pw, sh_ph;
    logic [16:0] sh_hs, sh_vs;

    face_hit_t hits_due[$];
    int        n_fail = 0;
    int        n_sent = 0;
    int        n_recv = 0;
    int        cycles = 0;

    cube_to_equirect_coord_map dut (.*);

    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap32(longint a);
        logic [31:0] u;
        u = a[31:0];
        return longint'($signed(u));
    endfunction

    function automatic void rot_sincos(input longint a, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 64'sh26DD3B6A;
        y = 0;
        z = wrap32(a);
        flip = 0;
        if (z > (64'sd1 <<< 30)) begin
            z = z - (64'sd1 <<< 31);
            flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = z + (64'sd1 <<< 31);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // atan of a non-negative q30 value, in 2^-32 turn
    function automatic longint vec_atan(longint v);
        longint x, y, z, dx, dy;
        x = 64'sd1 <<< 30;
        y = v;
        z = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint reg_lim(longint v, longint hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [19:0] onto_face(longint scale, longint n, longint a);
        longint q;
        if (a == 0) q = (n > 0) ? 2 * scale : (n < 0 ? 0 : scale);
        else q = scale + (scale * n) / a;
        if (q < 0) q = 0;
        if (q > 2 * scale) q = 2 * scale;
        return q[19:0];
    endfunction

    function automatic face_hit_t predict_hit(int col, int row);
        longint fs, w, h, theta, phi, eps, loc, ct, st, cp, sp, cl, sl, thr;
        longint vx, vy, vz, ax, nx, ny, scale, e8, q4, h2;
        logic [2:0] f;
        face_hit_t r;
        fs = reg_lim(sh_fs, MAX_FACE_SIZE);
        w  = reg_lim(sh_pw, MAX_PANO_DIM);
        h  = reg_lim(sh_ph, MAX_PANO_DIM);
        e8 = 64'sd1 <<< 29;
        q4 = 64'sd1 <<< 30;
        h2 = 64'sd1 <<< 31;
        theta = ((2 * longint'(col) - w) * longint'(sh_hs) * 32768) / w;
        phi   = ((2 * longint'(row) - h) * longint'(sh_vs) * 16384) / h;
        eps   = (64'sd1 <<< 32) / (80 * fs);
        // side faces by longitude
        if (theta > -e8 - eps && theta <= e8 - eps) begin
            f = FACE_FRONT; loc = theta;
        end else if (theta > -3 * e8 - eps && theta <= -e8 - eps) begin
            f = FACE_LEFT; loc = theta + q4;
        end else if (theta > e8 - eps && theta <= 3 * e8 - eps) begin
            f = FACE_RIGHT; loc = theta - q4;
        end else begin
            f = FACE_BACK; loc = (theta > 0) ? theta - h2 : theta + h2;
        end
        // top/down by latitude threshold
        rot_sincos(loc, cl, sl);
        if (cl > 0) thr = vec_atan(cl);
        else if (cl == 0) thr = 0;
        else thr = h2 - vec_atan(-cl);
        if (phi > thr) f = FACE_DOWN;
        else if (phi < -thr) f = FACE_TOP;
        rot_sincos(theta, ct, st);
        rot_sincos(phi, cp, sp);
        vx = fshift(cp * ct, 30);
        vy = sp;
        vz = fshift(cp * st, 30);
        case (f)
            FACE_FRONT: begin ax = vx; nx = vz;  ny = vy;  end
            FACE_LEFT:  begin ax = vz; nx = -vx; ny = -vy; end
            FACE_RIGHT: begin ax = vz; nx = -vx; ny = vy;  end
            FACE_BACK:  begin ax = vx; nx = vz;  ny = -vy; end
            FACE_TOP:   begin ax = vy; nx = -vz; ny = -vx; end
            default:    begin ax = vy; nx = vz;  ny = -vx; end
        endcase
        scale = fs * (64'sd1 <<< (FRAC_BITS - 1));
        r.face = f;
        r.fx = onto_face(scale, nx, ax);
        r.fy = onto_face(scale, ny, ax);
        return r;
    endfunction

    // ---------------- drivers ----------------
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FACE_SIZE:   sh_fs = val[11:0];
            REG_PANO_WIDTH:  sh_pw = val[13:0];
            REG_PANO_HEIGHT: sh_ph = val[13:0];
            REG_HORIZ_SPAN:  sh_hs = val[16:0];
            default:         sh_vs = val[16:0];
        endcase
    endtask

    task automatic set_all(int fs, int pw, int ph, int hs, int vs);
        reg_write(REG_FACE_SIZE, fs);
        reg_write(REG_PANO_WIDTH, pw);
        reg_write(REG_PANO_HEIGHT, ph);
        reg_write(REG_HORIZ_SPAN, hs);
        reg_write(REG_VERT_SPAN, vs);
    endtask

    // offer one pixel; returns after the edge that accepts it
    task automatic send_pixel(int col, int row);
        int        gap;
        bit        ok;
        face_hit_t hit;
        gap = ((n_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        hit = predict_hit(col, row);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, row[12:0], col[12:0]};
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        hits_due.push_back(hit);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (hits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_pixels(int n);
        int c, r, w, h;
        w = reg_lim(sh_pw, MAX_PANO_DIM);
        h = reg_lim(sh_ph, MAX_PANO_DIM);
        for (int i = 0; i < n; i++) begin
            // mostly inside the panorama, some anywhere in the field range
            if ($urandom_range(0, 99) < 80) begin
                c = $urandom_range(0, (w > 8192 ? 8192 : w) - 1);
                r = $urandom_range(0, (h > 8192 ? 8192 : h) - 1);
            end else begin
                c = $urandom_range(0, 8191);
                r = $urandom_range(0, 8191);
            end
            send_pixel(c, r);
        end
    endtask

    // ---------------- receiver and checker ----------------
    initial begin
        int        stall;
        bit        got;
        logic [47:0] d;
        face_hit_t e;
        @(posedge aclk iff aresetn);
        forever begin
            stall = ((n_recv / 64) % 4 == 1) ? 0 : $urandom_range(0, 13);
            if (n_recv == 40) stall = 2000; // long hold so the pipe backs up
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                d = m_tdata;
                @(posedge aclk);
            end while (!got);
            n_recv++;
            if (hits_due.size() == 0) begin
                $error("unexpected item face=%0d", d[2:0]);
                n_fail++;
            end else begin
                e = hits_due.pop_front();
                if (d[2:0] !== e.face) begin
                    $error("face exp %0d got %0d", e.face, d[2:0]);
                    n_fail++;
                end
                if (d[22:3] !== e.fx) begin
                    $error("face_x exp %0d got %0d", e.fx, d[22:3]);
                    n_fail++;
                end
                if (d[42:23] !== e.fy) begin
                    $error("face_y exp %0d got %0d", e.fy, d[42:23]);
                    n_fail++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    pix_row_t dir_tab[] = '{
        '{1024, 512, 0}, '{512, 512, 1}, '{1536, 512, 2}, '{0, 512, 3},
        '{1024, 0, 4}, '{1024, 1023, 5}, '{0, 0, 4}, '{2047, 1023, -1},
        '{8191, 8191, -1}, '{8191, 0, -1}, '{0, 8191, -1}, '{1280, 512, -1},
        '{768, 512, -1}, '{256, 256, -1}, '{1792, 900, -1}, '{1024, 511, -1}
    };

    initial begin
        face_hit_t p;
        sh_fs = 512; sh_pw = 2048; sh_ph = 1024; sh_hs = 65536; sh_vs = 65536;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pixels at reset defaults
        foreach (dir_tab[i]) begin
            if (dir_tab[i].face >= 0) begin
                p = predict_hit(dir_tab[i].col, dir_tab[i].row);
                if (p.face !== dir_tab[i].face[2:0]) begin
                    $error("face exp %0d got %0d", dir_tab[i].face, p.face);
                    n_fail++;
                end
            end
            send_pixel(dir_tab[i].col, dir_tab[i].row);
        end
        drain();

        // register extremes and out-of-range values
        set_all(1, 1, 1, 104, 209);
        send_pixel(0, 0);
        send_pixel(8191, 8191);
        send_pixel(1, 0);
        random_pixels(20);
        drain();
        set_all(2048, 8192, 8192, 65536, 65536);
        send_pixel(4096, 4096);
        send_pixel(0, 0);
        send_pixel(8191, 8191);
        random_pixels(200);
        drain();
        set_all(0, 0, 0, 131071, 131071);
        random_pixels(30);
        drain();
        set_all(4095, 16383, 16383, 0, 0);
        random_pixels(30);
        drain();

        // random settings
        for (int k = 0; k < 4; k++) begin
            set_all($urandom_range(1, 2048), $urandom_range(1, 8192),
                    $urandom_range(1, 8192), $urandom_range(104, 65536),
                    $urandom_range(209, 65536));
            random_pixels(50);
            drain();
        end

        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
